/* rtl/core/dcc_pkg.sv */
// Package for the drain cycle controller: item types, command and register codes,
// and the reset values of the configuration registers. It depends on nothing.
package dcc_pkg;

  // Commands carried in the mode field of an input item
  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_START  = 2'd1,
    MODE_CANCEL = 2'd2
  } mode_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_HALF_TIME   = 3'd0,
    REG_FULL_TIME   = 3'd1,
    REG_ROOM_BUDGET = 3'd2,
    REG_COLD_BUDGET = 3'd3,
    REG_LEVEL_WAIT  = 3'd4
  } reg_idx_e;

  localparam int unsigned TimeW   = 16;
  localparam int unsigned BudgetW = 10;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [TimeW-1:0]   HalfTimeRst   = 16'd1200;
  localparam logic [TimeW-1:0]   FullTimeRst   = 16'd60000;
  localparam logic [BudgetW-1:0] RoomBudgetRst = 10'd302;
  localparam logic [BudgetW-1:0] ColdBudgetRst = 10'd241;
  localparam logic [TimeW-1:0]   LevelWaitRst  = 16'd3000;

  typedef struct packed {
    logic [1:0] mode;
    logic       drain_kind;
    logic       dispensing;
    logic       out_is_room;
    logic       room_level_high;
    logic       room_level_fault;
    logic       cold_level_fault;
    logic       drain_fault;
    logic       sequence_done;
  } dcc_in_t;

  typedef struct packed {
    logic accepted;
    logic draining;
    logic full_active;
    logic restart_sequence;
    logic step_sequence;
  } dcc_out_t;

  // Current register values, handed from the register bank to the state logic
  typedef struct packed {
    logic [TimeW-1:0]   half_drain_time;
    logic [TimeW-1:0]   full_drain_time;
    logic [BudgetW-1:0] room_budget_init;
    logic [BudgetW-1:0] cold_budget_init;
    logic [TimeW-1:0]   level_wait_init;
  } dcc_cfg_t;

  typedef struct packed {
    logic               running;
    logic               full_mode;
    logic [TimeW-1:0]   time_left;
    logic [BudgetW-1:0] room_budget;
    logic [BudgetW-1:0] cold_budget;
    logic               level_reached;
    logic [TimeW-1:0]   level_wait;
  } dcc_state_t;

endpackage

/* rtl/core/dcc_cfg_regs.sv */
// Configuration register bank of the drain cycle controller.
// Depends on dcc_pkg for register indexes, widths and reset values.
module dcc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dcc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dcc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output dcc_pkg::dcc_cfg_t             cfg_o
);
  import dcc_pkg::*;

  dcc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HALF_TIME:   cfg_d.half_drain_time  = cfg_wdata_i[TimeW-1:0];
        REG_FULL_TIME:   cfg_d.full_drain_time  = cfg_wdata_i[TimeW-1:0];
        REG_ROOM_BUDGET: cfg_d.room_budget_init = cfg_wdata_i[BudgetW-1:0];
        REG_COLD_BUDGET: cfg_d.cold_budget_init = cfg_wdata_i[BudgetW-1:0];
        REG_LEVEL_WAIT:  cfg_d.level_wait_init  = cfg_wdata_i[TimeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_drain_time  <= HalfTimeRst;
      cfg_q.full_drain_time  <= FullTimeRst;
      cfg_q.room_budget_init <= RoomBudgetRst;
      cfg_q.cold_budget_init <= ColdBudgetRst;
      cfg_q.level_wait_init  <= LevelWaitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/dcc_state.sv */
// Drain supervisor state and its one-item update: budgets, level wait,
// duration count and the stop decision. Depends on dcc_pkg.
module dcc_state (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_en_i,
  input  dcc_pkg::dcc_in_t    item_i,
  input  dcc_pkg::dcc_cfg_t   cfg_i,
  output dcc_pkg::dcc_out_t   res_o
);
  import dcc_pkg::*;

  dcc_state_t st_q, st_d;
  logic [BudgetW-1:0] room_b, cold_b;
  logic halt, acc, restart, step;

  always_comb begin
    st_d    = st_q;
    halt    = 1'b0;
    acc     = 1'b0;
    restart = 1'b0;
    step    = 1'b0;
    room_b  = st_q.room_budget;
    cold_b  = st_q.cold_budget;
    unique case (item_i.mode)
      MODE_START: begin
        if (!item_i.drain_fault) begin
          st_d.running   = 1'b1;
          st_d.full_mode = item_i.drain_kind;
          st_d.time_left = item_i.drain_kind ? cfg_i.full_drain_time
                                             : cfg_i.half_drain_time;
          acc            = 1'b1;
          restart        = 1'b1;
        end
      end
      MODE_CANCEL: begin
        if (st_q.running) begin
          halt = 1'b1;
          acc  = 1'b1;
        end
      end
      MODE_TICK: begin
        // Dispensed water wears down the selected side's budget, floor at zero
        if (item_i.dispensing) begin
          if (item_i.out_is_room) begin
            if (room_b != '0) room_b = room_b - 1'b1;
          end else begin
            if (cold_b != '0) cold_b = cold_b - 1'b1;
          end
        end
        st_d.room_budget = room_b;
        st_d.cold_budget = cold_b;
        if (st_q.running) begin
          if (room_b == '0 || cold_b == '0) begin
            halt = 1'b1;
          end else if (!st_q.full_mode && !st_q.level_reached) begin
            // Half mode waits for the room tank; the tick that sees high still waits
            if (item_i.room_level_high) st_d.level_reached = 1'b1;
            if (st_q.level_wait != '0) begin
              st_d.level_wait = st_q.level_wait - 1'b1;
            end else begin
              halt = 1'b1;
            end
          end else if (st_q.time_left == '0 || item_i.room_level_fault ||
                       item_i.cold_level_fault || item_i.drain_fault) begin
            halt = 1'b1;
          end else begin
            st_d.time_left = st_q.time_left - 1'b1;
            step           = 1'b1;
            if (item_i.sequence_done) halt = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // Stop: reload budgets and level wait, drop the level flag
    if (halt) begin
      st_d.running       = 1'b0;
      st_d.room_budget   = cfg_i.room_budget_init;
      st_d.cold_budget   = cfg_i.cold_budget_init;
      st_d.level_reached = 1'b0;
      st_d.level_wait    = cfg_i.level_wait_init;
      restart            = 1'b1;
    end

    res_o.accepted         = acc;
    res_o.draining         = st_d.running;
    res_o.full_active      = st_d.running & st_d.full_mode;
    res_o.restart_sequence = restart;
    res_o.step_sequence    = step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.running       <= 1'b0;
      st_q.full_mode     <= 1'b0;
      st_q.time_left     <= '0;
      st_q.room_budget   <= RoomBudgetRst;
      st_q.cold_budget   <= ColdBudgetRst;
      st_q.level_reached <= 1'b0;
      st_q.level_wait    <= LevelWaitRst;
    end else if (step_en_i) begin
      st_q <= st_d;
    end
  end

endmodule

/* rtl/core/drain_cycle_controller_top.sv */
// Drain cycle controller top level: input item register, state update, result register.
// Depends on dcc_pkg, dcc_cfg_regs and dcc_state.
// Path: an accepted item passes the input register, then the result register, where its
//   result is shown until taken; throughput is one item per cycle while out_ready_i keeps
//   the result register moving, as the state update between the registers is combinational.
// Reset (rst_ni low, asynchronous): both registers empty, drain stopped, budgets and
//   level wait at their reset loads, configuration registers at their reset values.
module drain_cycle_controller_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  dcc_pkg::dcc_in_t              in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output dcc_pkg::dcc_out_t             out_item_o,
  input  logic                          cfg_we_i,
  input  logic [dcc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dcc_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import dcc_pkg::*;

  dcc_cfg_t cfg;
  dcc_in_t  item_q;
  logic     item_valid_q;
  dcc_out_t res, res_q;
  logic     res_valid_q;
  logic     advance;

  dcc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // Advance the held item into the result register when that slot is free
  // or is being emptied this cycle; the state updates on the same edge.
  assign advance    = item_valid_q & (~res_valid_q | out_ready_i);
  // Take a new item whenever the input register is empty or moves on
  assign in_ready_o = ~item_valid_q | advance;

  dcc_state u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_en_i(advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  // Input item register: hold the payload until it advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  // Result register: hold until taken downstream
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_item_o  = res_q;

endmodule

/* rtl/core/dcc_checker.sv */
// Port-level checks for the drain cycle controller, bound to the top level.
// Depends on dcc_pkg and drain_cycle_controller_top.
module dcc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input dcc_pkg::dcc_in_t              in_item_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input dcc_pkg::dcc_out_t             out_item_o
);
  import dcc_pkg::*;

  // An offered item waits with its payload until it is taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_item_i))
    else $error("input item changed while waiting");

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // Full mode is only reported while draining
  a_full_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.full_active |-> out_item_o.draining)
    else $error("full_active without draining");

  // Every accepted start or cancel reinitializes the sequence
  a_acc_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.accepted |-> out_item_o.restart_sequence)
    else $error("accepted without restart");

  // A step that ends the drain must restart the sequence, and a step never
  // comes with an accepted command
  a_step_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.step_sequence |->
      !out_item_o.accepted && (out_item_o.draining || out_item_o.restart_sequence))
    else $error("step result inconsistent");

endmodule

bind drain_cycle_controller_top dcc_checker u_dcc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_item_i  (in_item_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_o (out_item_o)
);
